// File: rtl/imd_pkg.sv
// Shared types and constants for the message deframer.
`timescale 1ns / 1ps

package imd_pkg;

   // Width of the raw byte counter and of the length limit register.
   localparam int unsigned RAW_W = 20;
   // Saturation value of the raw counter and reset value of the limit.
   localparam logic [RAW_W-1:0] RAW_MAX = 20'hFFFFF;
   // Packet bytes, type byte included, that follow a zero length byte.
   localparam logic [7:0] CONT_PAYLOAD = 8'd255;
   // Default number of entries in the queue between parser and output.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Error codes carried on the result channel.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_MISMATCH = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   // One queued result: a message byte, optionally followed by a closing NUL.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] error;
      logic       add_nul;
   } op_type;

   // Status of the queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/imd_front.sv
// Packet parser: accepts raw bytes, tracks framing and classifies results.
`timescale 1ns / 1ps

module imd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [imd_pkg::RAW_W-1:0] csr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  imd_pkg::queue_status_type q_status,
   output logic                      push,
   output imd_pkg::op_type           push_op
);
   import imd_pkg::*;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       bytes_left_ff, bytes_left_in;
   logic             in_cont_ff, in_cont_in;
   logic             first_ff, first_in;
   logic [7:0]       msg_type_ff, msg_type_in;
   logic [7:0]       held_byte_ff, held_byte_in;
   logic             held_valid_ff, held_valid_in;
   logic             discard_ff, discard_in;
   logic [RAW_W-1:0] raw_count_ff, raw_count_in;
   logic [RAW_W-1:0] max_raw_ff;
   logic             accept;
   logic             has_res;
   op_type           res;

   // The parser only stalls when the queue has no room.
   assign req_tready = !q_status.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && has_res;
   assign push_op    = res;

   // Next state and the result caused by the byte on req_tdata.
   always_comb begin
      logic [7:0] b;
      logic [7:0] bl;
      logic       done;
      b             = req_tdata;
      bl            = bytes_left_ff - 8'd1;
      done          = 1'b0;
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      in_cont_in    = in_cont_ff;
      first_in      = first_ff;
      msg_type_in   = msg_type_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      discard_in    = discard_ff;
      has_res       = 1'b0;
      res           = '{data: 8'd0, last: 1'b0, error: ERR_NONE, add_nul: 1'b0};

      // Length limit check comes before anything else on this byte.
      if (!discard_ff && raw_count_ff >= max_raw_ff) begin
         has_res       = 1'b1;
         res           = '{data: 8'd0, last: 1'b1, error: ERR_TOO_LONG, add_nul: 1'b0};
         discard_in    = 1'b1;
         held_valid_in = 1'b0;
      end
      raw_count_in = raw_count_ff + ((raw_count_ff != RAW_MAX) ? {{(RAW_W-1){1'b0}}, 1'b1}
                                                               : {RAW_W{1'b0}});

      unique case (phase_ff)
         PH_TYPE: begin
            bytes_left_in = bl;
            if (first_ff) begin
               // The first type byte opens the message.
               msg_type_in = b;
               first_in    = 1'b0;
               if (!discard_in) begin
                  has_res = 1'b1;
                  if (bl == 8'd0 && b == 8'd0) begin
                     res = '{data: 8'd0, last: 1'b1, error: ERR_NONE, add_nul: 1'b0};
                  end else begin
                     res = '{data: b, last: 1'b0, error: ERR_NONE,
                             add_nul: (bl == 8'd0)};
                  end
               end
            end else if (!discard_in && b != msg_type_ff) begin
               has_res       = 1'b1;
               res           = '{data: 8'd0, last: 1'b1, error: ERR_MISMATCH, add_nul: 1'b0};
               discard_in    = 1'b1;
               held_valid_in = 1'b0;
            end else if (bl == 8'd0 && !discard_in) begin
               // A final packet with only a type byte closes on the held byte.
               has_res = 1'b1;
               if (held_valid_in && held_byte_ff != 8'd0) begin
                  res = '{data: held_byte_ff, last: 1'b0, error: ERR_NONE, add_nul: 1'b1};
               end else begin
                  res = '{data: 8'd0, last: 1'b1, error: ERR_NONE, add_nul: 1'b0};
               end
            end
            if (bl == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            bytes_left_in = bl;
            if (in_cont_ff) begin
               if (bl >= 8'd2) begin
                  if (!discard_in) begin
                     has_res = 1'b1;
                     res     = '{data: b, last: 1'b0, error: ERR_NONE, add_nul: 1'b0};
                  end
               end else if (bl == 8'd1 || b != 8'd0) begin
                  // Keep the byte back until we know whether it ends the message.
                  if (held_valid_in && !discard_in) begin
                     has_res = 1'b1;
                     res     = '{data: held_byte_ff, last: 1'b0, error: ERR_NONE,
                                 add_nul: 1'b0};
                  end
                  held_byte_in  = b;
                  held_valid_in = !discard_in;
               end
               if (bl == 8'd0) begin
                  phase_in = PH_LEN;
               end
            end else begin
               if (!discard_in) begin
                  has_res = 1'b1;
                  if (bl == 8'd0 && b == 8'd0) begin
                     res = '{data: 8'd0, last: 1'b1, error: ERR_NONE, add_nul: 1'b0};
                  end else begin
                     res = '{data: b, last: 1'b0, error: ERR_NONE, add_nul: (bl == 8'd0)};
                  end
               end
               if (bl == 8'd0) begin
                  done = 1'b1;
               end
            end
         end
         default: begin
            // Length byte: zero starts a continuation packet.
            if (b == 8'd0) begin
               in_cont_in    = 1'b1;
               bytes_left_in = CONT_PAYLOAD;
            end else begin
               in_cont_in    = 1'b0;
               bytes_left_in = b;
            end
            if (!first_ff && b != 8'd1) begin
               if (held_valid_in && !discard_in) begin
                  has_res = 1'b1;
                  res     = '{data: held_byte_ff, last: 1'b0, error: ERR_NONE, add_nul: 1'b0};
               end
               held_valid_in = 1'b0;
            end
            phase_in = PH_TYPE;
         end
      endcase

      // End of message: everything but the type starts over.
      if (done) begin
         phase_in      = PH_LEN;
         bytes_left_in = 8'd0;
         in_cont_in    = 1'b0;
         first_in      = 1'b1;
         held_valid_in = 1'b0;
         held_byte_in  = 8'd0;
         discard_in    = 1'b0;
         raw_count_in  = {RAW_W{1'b0}};
      end
   end

   // Parser state and the length limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         bytes_left_ff <= 8'd0;
         in_cont_ff    <= 1'b0;
         first_ff      <= 1'b1;
         msg_type_ff   <= 8'd0;
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         discard_ff    <= 1'b0;
         raw_count_ff  <= {RAW_W{1'b0}};
         max_raw_ff    <= RAW_MAX;
      end else begin
         if (csr_valid && csr_ready) begin
            max_raw_ff <= csr_data;
         end
         if (accept) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            in_cont_ff    <= in_cont_in;
            first_ff      <= first_in;
            msg_type_ff   <= msg_type_in;
            held_byte_ff  <= held_byte_in;
            held_valid_ff <= held_valid_in;
            discard_ff    <= discard_in;
            raw_count_ff  <= raw_count_in;
         end
      end
   end

endmodule

// File: rtl/imd_queue.sv
// Small register queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module imd_queue #(
   parameter int unsigned DEPTH = imd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  imd_pkg::op_type           push_op,
   input  logic                      pop,
   output imd_pkg::op_type           pop_op,
   output imd_pkg::queue_status_type status
);
   import imd_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type           entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == {CNT_W{1'b0}});
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_op       = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? {PTR_W{1'b0}} : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? {PTR_W{1'b0}} : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= {PTR_W{1'b0}};
         rd_ptr_ff <= {PTR_W{1'b0}};
         count_ff  <= {CNT_W{1'b0}};
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: rtl/imd_back.sv
// Output stage: turns queued results into beats, adding the closing NUL.
`timescale 1ns / 1ps

module imd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  imd_pkg::queue_status_type q_status,
   input  imd_pkg::op_type           pop_op,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser
);
   import imd_pkg::*;

   logic       valid_ff, valid_in;
   logic       nul_ff, nul_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [1:0] error_ff, error_in;
   logic       advance;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = error_ff;
   assign advance    = !valid_ff || rsp_tready;
   assign pop        = advance && !nul_ff && !q_status.empty;

   // Load the next beat: a pending NUL first, else the queue head.
   always_comb begin
      valid_in = valid_ff;
      nul_in   = nul_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      error_in = error_ff;
      if (advance) begin
         if (nul_ff) begin
            valid_in = 1'b1;
            nul_in   = 1'b0;
            data_in  = 8'd0;
            last_in  = 1'b1;
            error_in = ERR_NONE;
         end else if (!q_status.empty) begin
            valid_in = 1'b1;
            nul_in   = pop_op.add_nul;
            data_in  = pop_op.data;
            last_in  = pop_op.last;
            error_in = pop_op.error;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         nul_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         nul_ff   <= nul_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

endmodule

// File: rtl/icb_message_deframer.sv
// Top level of the length-prefixed message deframer.
`timescale 1ns / 1ps
// A result passes through the queue and the output register before it is offered on rsp.
// Throughput: one input beat per cycle; a result with an appended NUL is followed on the
// result port by its own NUL beat, and the parser stalls only when the result queue is full.
// Reset (synchronous, active high) returns the parser to expecting a length byte, empties the
// queue and the output stage, and sets the length limit to its largest value.

module icb_message_deframer #(
   parameter int unsigned QUEUE_DEPTH = imd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Length limit register write channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [imd_pkg::RAW_W-1:0] csr_data,   // [19:0] max_raw_len
   // Raw byte input.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [7:0] in_byte
   // Message byte output.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // [7:0] out_byte
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser   // [1:0] error
);
   import imd_pkg::*;

   queue_status_type q_status;
   logic             push, pop;
   op_type           push_op, pop_op;

   imd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_op    (push_op)
   );

   imd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .status  (q_status)
   );

   imd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_op     (pop_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
